// File: rtl/ocwc_pkg.sv
// Shared widths and types for the one's complement word checksum.
package ocwc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned SUM_W  = 64;
	localparam int unsigned POS_W  = 2;

	// Final 64-bit word sum of one payload, moving towards the fold stage
	typedef struct packed {
		logic              valid;
		logic [SUM_W-1:0]  sum;
	} ocwc_sum_t;

endpackage

// File: rtl/ocwc_pack_acc.sv
// Input register, big-endian word packer and 64-bit word accumulator.
module ocwc_pack_acc
	import ocwc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_byte,
	output ocwc_sum_t         sum_s2,
	input  logic              down_ready
);

	logic              v_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              last_s1;

	logic [WORD_W-1:0] pending_q;
	logic [POS_W-1:0]  pos_q;
	logic [SUM_W-1:0]  acc_q;

	logic              en2;
	logic              step;
	logic [4:0]        shamt;
	logic [WORD_W-1:0] word;
	logic              word_done;
	logic [SUM_W-1:0]  acc_add;

	assign en2      = !sum_s2.valid || down_ready;
	assign step     = v_s1 && en2;
	assign in_ready = !v_s1 || en2;

	// first byte of a word lands in bits 31..24: shift by 8 * (3 - pos)
	assign shamt     = {~pos_q, 3'b000};
	assign word      = pending_q | ({{(WORD_W-BYTE_W){1'b0}}, data_s1} << shamt);
	assign word_done = (pos_q == POS_W'(3)) || last_s1;
	assign acc_add   = acc_q + {{(SUM_W-WORD_W){1'b0}}, word};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			pos_q     <= '0;
			acc_q     <= '0;
		end else if (step) begin
			if (word_done) begin
				pending_q <= '0;
				pos_q     <= '0;
				acc_q     <= last_s1 ? '0 : acc_add;
			end else begin
				pending_q <= word;
				pos_q     <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_s2 <= '0;
		end else begin
			if (en2) begin
				sum_s2.valid <= step && last_s1;
			end
			if (step && last_s1) begin
				sum_s2.sum <= acc_add;
			end
		end
	end

endmodule

// File: rtl/ocwc_fold.sv
// Folds the 64-bit sum to 32 bits with end-around carry and complements it.
module ocwc_fold
	import ocwc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ocwc_sum_t         sum_s2,
	output logic              up_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] checksum_value
);

	logic              v_s3;
	logic [WORD_W:0]   fold_s3;
	logic              load_out;
	logic              en3;
	logic [WORD_W-1:0] wrapped;

	assign load_out = !out_valid || out_ready;
	assign en3      = !v_s3 || load_out;
	assign up_ready = en3;

	// carry out of the fold is at most one, so one more add closes it
	assign wrapped = fold_s3[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, fold_s3[WORD_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en3) begin
				v_s3 <= sum_s2.valid;
			end
			if (load_out) begin
				out_valid <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && sum_s2.valid) begin
			fold_s3 <= {1'b0, sum_s2.sum[SUM_W-1:WORD_W]}
				+ {1'b0, sum_s2.sum[WORD_W-1:0]};
		end
		if (load_out && v_s3) begin
			checksum_value <= ~wrapped;
		end
	end

endmodule

// File: rtl/ones_complement_word_checksum.sv
// Throughput: one byte request per cycle; out_ready low stalls the pipe.
// Stages: input register + packer/accumulator, 33-bit fold, end-around carry + output reg.
// Reset (arst_n, async): clears valids, packer position, pending word and accumulator.
// Output register parts the sides: input still flows while a checksum waits.
module ones_complement_word_checksum
	import ocwc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] checksum_value
);

	ocwc_sum_t sum_s2;
	logic      fold_ready;

	ocwc_pack_acc u_pack_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.sum_s2     (sum_s2),
		.down_ready (fold_ready)
	);

	ocwc_fold u_fold (
		.clk            (clk),
		.arst_n         (arst_n),
		.sum_s2         (sum_s2),
		.up_ready       (fold_ready),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.checksum_value (checksum_value)
	);

endmodule

// File: rtl/ocwc_checker.sv
// Port-level checks for the checksum block and their binding to the top level.
module ocwc_checker
	import ocwc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              last_byte,
	input logic              out_valid,
	input logic              out_ready,
	input logic [WORD_W-1:0] checksum_value
);

	// final bytes taken whose checksum has not left yet; at most four in flight
	logic [2:0] owed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= '0;
		end else begin
			owed_q <= owed_q + {2'b00, in_valid && in_ready && last_byte}
				- {2'b00, out_valid && out_ready};
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(checksum_value))
		else $error("checksum dropped or changed while stalled");

	// a free output side never stalls the input
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("in_ready low while out_ready high");

	// last byte taken and output draining: result once it has passed the input, sum, fold and output registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_byte ##1 out_ready ##1 out_ready ##1 out_ready
		|=> out_valid)
		else $error("checksum late for final byte request");

	// nothing appears without a final byte taken earlier
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> owed_q != 3'd0)
		else $error("out_valid with no final byte request outstanding");

endmodule

bind ones_complement_word_checksum ocwc_checker u_ocwc_checker (.*);
